>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check is sampled on aclk and is off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/s4rf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s4rf_pkg
// Types, constants and the rule match function of the SOCKS4 request filter.
// ---------------------------------------------------------------------------
package s4rf_pkg;

    localparam int RULE_SLOTS = 8;
    localparam int RULE_COUNT = 8;
    localparam int RULE_W     = 39;
    localparam int RULE_IDX_W = $clog2(RULE_SLOTS);
    localparam int PADDR_W    = RULE_IDX_W + 3;
    localparam int APB_DATA_W = 64;

    localparam logic [7:0] SOCKS_VERSION = 8'h04;
    localparam logic [7:0] CMD_CONNECT   = 8'd1;
    localparam logic [7:0] CMD_BIND      = 8'd2;

    localparam logic [3:0] POS_USER_ID = 4'd8;

    localparam logic [1:0] VERDICT_GRANT       = 2'd0;
    localparam logic [1:0] VERDICT_REJECT      = 2'd1;
    localparam logic [1:0] VERDICT_BAD_VERSION = 2'd2;
    localparam logic [1:0] VERDICT_BAD_COMMAND = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [RULE_W-1:0] rule_t;
    typedef logic [RULE_SLOTS-1:0][RULE_W-1:0] rule_tab_t;

    // One parsed request as it travels from the parser to the judge.
    typedef struct packed {
        logic        lookup;   // header is sound, verdict comes from the table
        logic [1:0]  verdict;  // final verdict when no lookup is needed
        logic [7:0]  command;
        logic [15:0] port;
        logic [31:0] addr;
    } req_t;

    // Rule layout: valid in bit 0, mode in bits 2:1, octet wildcards in bits
    // 6:3 (bit 3 covers the first address byte on the wire), address above.
    function automatic logic rule_hit(rule_t r, logic [7:0] cmd, logic [31:0] addr);
        logic        hit;
        logic [31:0] raddr;
        hit   = r[0] && ({6'd0, r[2:1]} == cmd);
        raddr = r[38:7];
        for (int i = 0; i < 4; i++) begin
            if (!r[3+i] && (addr[31-8*i -: 8] != raddr[31-8*i -: 8])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/s4rf_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// s4rf_parser
// Front end: takes request beats, collects the header, skips the user ID and
// pushes a screened request into the queue at the terminator.
// ---------------------------------------------------------------------------
module s4rf_parser import s4rf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       q_full,
    output logic       push,
    output req_t       push_req
);

    logic [3:0]  pos_reg, pos_next;
    logic        ver_ok_reg, ver_ok_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] addr_reg, addr_next;
    logic        take;
    logic        cmd_ok;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign cmd_ok  = (cmd_reg == CMD_CONNECT) || (cmd_reg == CMD_BIND);

    always_comb begin
        pos_next    = pos_reg;
        ver_ok_next = ver_ok_reg;
        cmd_next    = cmd_reg;
        port_next   = port_reg;
        addr_next   = addr_reg;
        push        = 1'b0;
        if (take) begin
            case (pos_reg)
                4'd0: ver_ok_next = (s_data_byte == SOCKS_VERSION);
                4'd1: cmd_next = s_data_byte;
                4'd2: port_next[15:8] = s_data_byte;
                4'd3: port_next[7:0] = s_data_byte;
                4'd4, 4'd5, 4'd6, 4'd7: addr_next = {addr_reg[23:0], s_data_byte};
                default: begin
                    if (s_data_byte == 8'h00) begin
                        push = 1'b1;
                    end
                end
            endcase
            if (pos_reg != POS_USER_ID) begin
                pos_next = pos_reg + 4'd1;
            end else if (s_data_byte == 8'h00) begin
                pos_next = 4'd0;
            end
        end
    end

    // Version is checked before the command, as the verdict codes rank them.
    always_comb begin
        push_req.command = cmd_reg;
        push_req.port    = port_reg;
        push_req.addr    = addr_reg;
        push_req.lookup  = 1'b0;
        if (!ver_ok_reg) begin
            push_req.verdict = VERDICT_BAD_VERSION;
        end else if (!cmd_ok) begin
            push_req.verdict = VERDICT_BAD_COMMAND;
        end else begin
            push_req.verdict = VERDICT_REJECT;
            push_req.lookup  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        ver_ok_reg <= ver_ok_next;
        cmd_reg    <= cmd_next;
        port_reg   <= port_next;
        addr_reg   <= addr_next;
    end

    `ASSERT_IMPL(a_pos_range, 1'b1, pos_reg <= POS_USER_ID)
    `ASSERT_IMPL(a_push_room, push, !q_full)

endmodule

>>> rtl/s4rf_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// s4rf_queue
// Short request queue between the parser and the judge.
// ---------------------------------------------------------------------------
module s4rf_queue import s4rf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  req_t push_req,
    output logic full,
    output logic head_valid,
    output req_t head_req,
    input  logic pop
);

    req_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_pop;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_req   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= Q_CNT_W'(Q_DEPTH))

endmodule

>>> rtl/s4rf_judge.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// s4rf_judge
// Back end: matches the queued request against the rule table and holds the
// verdict in an output register until the result beat is taken.
// ---------------------------------------------------------------------------
module s4rf_judge import s4rf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  rule_tab_t   rules,
    input  logic        head_valid,
    input  req_t        head_req,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict,
    output logic [7:0]  m_command_code,
    output logic [15:0] m_dest_port,
    output logic [31:0] m_dest_ip
);

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  verdict_reg;
    logic [7:0]  command_reg;
    logic [15:0] port_reg;
    logic [31:0] addr_reg;
    logic        any_hit;
    logic [1:0]  verdict_next;

    // All active rules are compared in parallel; any hit grants.
    always_comb begin
        any_hit = 1'b0;
        for (int i = 0; i < RULE_COUNT; i++) begin
            if (rule_hit(rules[i], head_req.command, head_req.addr)) begin
                any_hit = 1'b1;
            end
        end
        if (head_req.lookup) begin
            verdict_next = any_hit ? VERDICT_GRANT : VERDICT_REJECT;
        end else begin
            verdict_next = head_req.verdict;
        end
    end

    assign pop = head_valid && (!out_valid_reg || m_ready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            verdict_reg <= verdict_next;
            command_reg <= head_req.command;
            port_reg    <= head_req.port;
            addr_reg    <= head_req.addr;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_verdict      = verdict_reg;
    assign m_command_code = command_reg;
    assign m_dest_port    = port_reg;
    assign m_dest_ip      = addr_reg;

    `ASSERT_NEXT(a_pop_loads, pop, out_valid_reg)

endmodule

>>> rtl/socks4_request_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// socks4_request_filter
// SOCKS4 request whitelist filter: parses a request byte stream and gives
// one verdict per request, checked against eight configurable rules.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake              Beat content
//  s_        in         s_valid / s_ready      one request byte
//  m_        out        m_valid / m_ready      verdict, command, port, address
//  APB       in         psel/penable/pready    rule_0..rule_7 at 8*i
//
// One request byte is taken every cycle while the request queue has room. A
// verdict passes from the user ID terminator beat through the request queue,
// then through the parallel rule compare into the output register.
// Reset is synchronous and clears the parser position, the queue, the output
// valid and all rules. There is no clearing pass.
// The input stalls only while the two-entry request queue is full.
// ---------------------------------------------------------------------------
module socks4_request_filter import s4rf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_verdict,
    output logic [7:0]            m_command_code,
    output logic [15:0]           m_dest_port,
    output logic [31:0]           m_dest_ip,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    rule_tab_t             rule_reg;
    logic [RULE_IDX_W-1:0] reg_idx;
    logic                  cfg_wr;
    logic                  q_full;
    logic                  push;
    req_t                  push_req;
    logic                  head_valid;
    req_t                  head_req;
    logic                  pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = {(APB_DATA_W - RULE_W)'(0), rule_reg[reg_idx]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg <= '0;
        end else if (cfg_wr) begin
            rule_reg[reg_idx] <= pwdata[RULE_W-1:0];
        end
    end

    s4rf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .push        (push),
        .push_req    (push_req)
    );

    s4rf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .full       (q_full),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop)
    );

    s4rf_judge u_judge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rules          (rule_reg),
        .head_valid     (head_valid),
        .head_req       (head_req),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_command_code (m_command_code),
        .m_dest_port    (m_dest_port),
        .m_dest_ip      (m_dest_ip)
    );

endmodule

>>> tb/socks4_request_filter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// socks4_request_filter_tb
// Streams SOCKS4 request bytes into the filter under varying rule tables and
// handshake pressure. A scoreboard parses the same bytes, decides each verdict
// against its own copy of the rule table and compares every output beat.
// ---------------------------------------------------------------------------
module socks4_request_filter_tb import s4rf_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [7:0]  command;
        logic [15:0] port;
        logic [31:0] addr;
    } verdict_rec_t;

    // Tracks the request parser and the rule table, and holds the verdicts
    // still to come out of the block.
    class socks4_verdict_board;
        logic [RULE_W-1:0] rule_tab [RULE_SLOTS];
        int unsigned       pos;
        logic [7:0]        version;
        logic [7:0]        command;
        logic [15:0]       port;
        logic [31:0]       addr;
        verdict_rec_t      awaited_verdicts [$];
        int unsigned       errors;

        function new();
            foreach (rule_tab[i]) rule_tab[i] = '0;
            errors = 0;
            clear_request();
        endfunction

        function void clear_request();
            pos     = 0;
            version = '0;
            command = '0;
            port    = '0;
            addr    = '0;
        endfunction

        function void set_rule(int idx, logic [63:0] value);
            if (idx < RULE_SLOTS) rule_tab[idx] = value[RULE_W-1:0];
        endfunction

        function bit rule_admits(logic [RULE_W-1:0] r);
            if (!r[0] || {6'd0, r[2:1]} != command) return 1'b0;
            for (int i = 0; i < 4; i++) begin
                if (!r[3+i] && addr[31-8*i -: 8] != r[38-8*i -: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function logic [1:0] judge();
            if (version != SOCKS_VERSION) return VERDICT_BAD_VERSION;
            if (command != CMD_CONNECT && command != CMD_BIND) return VERDICT_BAD_COMMAND;
            for (int i = 0; i < RULE_COUNT; i++) begin
                if (rule_admits(rule_tab[i])) return VERDICT_GRANT;
            end
            return VERDICT_REJECT;
        endfunction

        function void note_byte(logic [7:0] b);
            verdict_rec_t rec;
            case (pos)
                0: version = b;
                1: command = b;
                2: port[15:8] = b;
                3: port[7:0] = b;
                4, 5, 6, 7: addr = {addr[23:0], b};
                default: begin
                    // Inside the user ID only a zero byte does anything.
                    if (b == 8'd0) begin
                        rec.verdict = judge();
                        rec.command = command;
                        rec.port    = port;
                        rec.addr    = addr;
                        awaited_verdicts.push_back(rec);
                        clear_request();
                    end
                    return;
                end
            endcase
            pos++;
        endfunction

        function void check_verdict(logic [1:0] v, logic [7:0] c, logic [15:0] p,
                                    logic [31:0] a);
            verdict_rec_t rec;
            if (awaited_verdicts.size() == 0) begin
                $error("verdict beat with none expected: verdict %0d addr %h", v, a);
                errors++;
                return;
            end
            rec = awaited_verdicts.pop_front();
            if (v !== rec.verdict) begin
                $error("verdict: expected %0d, got %0d", rec.verdict, v);
                errors++;
            end
            if (c !== rec.command) begin
                $error("command_code: expected %h, got %h", rec.command, c);
                errors++;
            end
            if (p !== rec.port) begin
                $error("dest_port: expected %h, got %h", rec.port, p);
                errors++;
            end
            if (a !== rec.addr) begin
                $error("dest_ip: expected %h, got %h", rec.addr, a);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte    = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [1:0]            m_verdict;
    logic [7:0]            m_command_code;
    logic [15:0]           m_dest_port;
    logic [31:0]           m_dest_ip;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [PADDR_W-1:0]    paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    socks4_verdict_board board;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_request  = 0;
    int unsigned         bytes_sent    = 0;
    int unsigned         cycle_count   = 0;
    logic [31:0]         addr_pool [4];

    socks4_request_filter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_command_code (m_command_code),
        .m_dest_port    (m_dest_port),
        .m_dest_ip      (m_dest_ip),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check each accepted beat, then pick ready for the next edge.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_verdict(m_verdict, m_command_code, m_dest_port, m_dest_ip);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // All driving tasks are entered and left just after a rising edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_request(input logic [7:0] ver, input logic [7:0] cmd,
                                input logic [15:0] dport, input logic [31:0] daddr,
                                input int uid_len);
        send_byte(ver);
        send_byte(cmd);
        send_byte(dport[15:8]);
        send_byte(dport[7:0]);
        for (int i = 0; i < 4; i++) send_byte(daddr[31-8*i -: 8]);
        repeat (uid_len) send_byte(8'($urandom_range(255, 1)));
        send_byte(8'd0);
    endtask

    // Brings the parser back to the start of a request.
    task automatic finish_request();
        while (board.pos != 0) begin
            send_byte((board.pos >= POS_USER_ID) ? 8'd0 : 8'($urandom_range(255)));
        end
    endtask

    task automatic wait_all_verdicts();
        s_valid <= 1'b0;
        while (board.awaited_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_rule(input int idx, input logic [63:0] value);
        logic [PADDR_W-1:0] reg_addr;
        reg_addr = PADDR_W'(8 * idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.set_rule(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [RULE_W-1:0] make_rule(input bit valid, input logic [1:0] mode,
                                                    input logic [3:0] wild,
                                                    input logic [31:0] a);
        return {a, wild, mode, valid};
    endfunction

    task automatic fresh_address_pool();
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
    endtask

    // Rules built around the address pool, so that grants stay common.
    task automatic load_pool_rules(input bit junk_high);
        logic [RULE_W-1:0] r;
        logic [63:0]       word;
        logic [1:0]        mode;
        logic [3:0]        wild;
        for (int i = 0; i < RULE_SLOTS; i++) begin
            word = {$urandom, $urandom};
            mode = ($urandom_range(9) == 0) ? 2'($urandom_range(3))
                                            : 2'($urandom_range(2, 1));
            wild = 4'($urandom_range(15) & $urandom_range(15));
            if ($urandom_range(7) == 0) r = word[RULE_W-1:0];
            else r = make_rule($urandom_range(7) != 0, mode, wild,
                               addr_pool[$urandom_range(3)]);
            word = {$urandom, $urandom};
            write_rule(i, junk_high ? {word[63:RULE_W], r} : {{(64-RULE_W){1'b0}}, r});
        end
    endtask

    function automatic logic [31:0] pick_dest();
        logic [31:0] a;
        int          k;
        if ($urandom_range(99) < 65) begin
            a = addr_pool[$urandom_range(3)];
            if ($urandom_range(9) < 3) begin
                k = $urandom_range(3);
                a[8*k +: 8] = 8'($urandom_range(255));
            end
        end else begin
            a = $urandom;
        end
        return a;
    endfunction

    // Mostly complete requests with random content, the rest raw noise that
    // throws the parser off its framing.
    task automatic random_traffic(input int unsigned budget);
        int unsigned target;
        logic [7:0]  ver;
        logic [7:0]  cmd;
        int          uid_len;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 85) begin
                ver     = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : SOCKS_VERSION;
                cmd     = ($urandom_range(99) < 85) ? 8'($urandom_range(2, 1))
                                                    : 8'($urandom_range(255));
                uid_len = ($urandom_range(9) == 0) ? $urandom_range(24, 6) : $urandom_range(4);
                send_request(ver, cmd, 16'($urandom_range(65535)), pick_dest(), uid_len);
            end else begin
                repeat ($urandom_range(12, 1)) begin
                    send_byte(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)));
                end
            end
        end
        finish_request();
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 7;
        recv_idle_pct = 60;

        // Table still empty from reset: a sound request is rejected.
        send_request(SOCKS_VERSION, CMD_CONNECT, 16'hFFFF, 32'hFFFF_FFFF, 0);
        // An all-zero header is still parsed as header data.
        send_request(8'h00, 8'h00, 16'h0000, 32'h0000_0000, 0);
        send_request(SOCKS_VERSION, 8'hFF, 16'h0050, 32'h0A00_0001, 1);
        wait_all_verdicts();

        write_rule(0, 64'(make_rule(1'b1, CMD_CONNECT[1:0], 4'b0000, 32'h0A00_0001)));
        write_rule(1, 64'(make_rule(1'b1, CMD_BIND[1:0], 4'b1110, 32'hC000_0000)));
        write_rule(2, '0);
        write_rule(3, '0);
        write_rule(4, '0);
        write_rule(5, '0);
        write_rule(6, '0);
        // A rule that would match every connect, but is not valid.
        write_rule(7, 64'(make_rule(1'b0, CMD_CONNECT[1:0], 4'b1111, 32'h0)));

        send_request(SOCKS_VERSION, CMD_CONNECT, 16'd80, 32'h0A00_0001, 0);
        send_request(SOCKS_VERSION, CMD_BIND, 16'd0, 32'hC0A8_0105, 2);
        send_request(SOCKS_VERSION, CMD_CONNECT, 16'd443, 32'hC0A8_0105, 0);
        // Version is judged before the command.
        send_request(8'h05, 8'h03, 16'h1234, 32'h0A00_0001, 0);
        send_request(SOCKS_VERSION, CMD_BIND, 16'h8000, 32'h0A00_0001, 20);
        send_request(SOCKS_VERSION, 8'h00, 16'h0001, 32'h7F00_0001, 0);
        wait_all_verdicts();

        fresh_address_pool();
        load_pool_rules(1'b0);
        random_traffic(300);
        wait_all_verdicts();

        send_idle_pct = 60;
        recv_idle_pct = 7;
        // Every rule valid with mode 3, which never matches a connect or bind.
        for (int i = 0; i < RULE_SLOTS; i++) write_rule(i, '1);
        random_traffic(100);
        wait_all_verdicts();

        fresh_address_pool();
        load_pool_rules(1'b1);
        random_traffic(250);
        wait_all_verdicts();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        fresh_address_pool();
        load_pool_rules(1'b0);
        // The result side stops for a while so that the request queue fills
        // up and the input has to stall.
        hold_request = HOLD_CYCLES;
        random_traffic(300);
        wait_all_verdicts();

        if (board.awaited_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", board.awaited_verdicts.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
